FILE: rtl/fptb_pkg.sv
// Shared types, constants and codes of the four-level page table builder.
`timescale 1ns / 1ps

package fptb_pkg;

  localparam int unsigned POOL_PAGES_DEFAULT = 64;

  localparam int unsigned VA_W             = 48;
  localparam int unsigned PA_W             = 52;
  localparam int unsigned CNT_W            = 7;
  localparam int unsigned BYTES_W          = 19;
  localparam int unsigned ENTRY_W          = 64;
  localparam int unsigned OFFSET_W         = 12;
  localparam int unsigned IDX_W            = 9;
  localparam int unsigned ENTRIES_PER_PAGE = 512;

  localparam logic [OFFSET_W-1:0] ENTRY_FLAGS = 12'h003;

  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_ALLOC = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MISALIGNED = 2'd1;
  localparam logic [1:0] ST_MAPPED     = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [VA_W-1:0]  virt_addr;
    logic [PA_W-1:0]  leaf_pa;
    logic [CNT_W-1:0] num_pages;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               is_mapped;
    logic [VA_W-1:0]    alloc_addr;
    logic [BYTES_W-1:0] alloc_bytes;
  } rsp_t;

  typedef struct packed {
    logic       capture;
    logic       walk_start;
    logic       mem_rd;
    logic       descend;
    logic       fresh_clear;
    logic       link;
    logic       leaf_write;
    logic       alloc_commit;
    logic       clr_step;
    logic       res_set;
    logic [1:0] res_status;
    logic       res_mapped;
    logic       res_alloc;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       misaligned;
    logic       can_alloc;
    logic       count_zero;
    logic       can_fresh;
    logic       entry_zero;
    logic       ptr_ok;
    logic       leaf_lvl;
    logic       clr_last;
  } dp_sts_t;

endpackage

FILE: rtl/fptb_ctrl.sv
// Controller state machine that sequences walks, allocations and clearing sweeps.
`timescale 1ns / 1ps

module fptb_ctrl
  import fptb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DISPATCH = 3'd2;
  localparam logic [2:0] S_READ     = 3'd3;
  localparam logic [2:0] S_CHECK    = 3'd4;
  localparam logic [2:0] S_LINK     = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_DONE = 2'd1;
  localparam logic [1:0] R_LINK = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] ret_q, ret_d;
  logic       out_valid_q, out_valid_d;
  logic       is_query;

  assign is_query    = (sts_i.op == OP_QUERY);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          case (ret_q)
            R_DONE:  state_d = S_DONE;
            R_LINK:  state_d = S_LINK;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.op)
          OP_MAP: begin
            if (sts_i.misaligned) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ST_MISALIGNED;
              state_d          = S_DONE;
            end else begin
              cmd_o.walk_start = 1'b1;
              state_d          = S_READ;
            end
          end
          OP_QUERY: begin
            cmd_o.walk_start = 1'b1;
            state_d          = S_READ;
          end
          OP_ALLOC: begin
            cmd_o.res_set = 1'b1;
            if (sts_i.can_alloc) begin
              cmd_o.res_status   = ST_OK;
              cmd_o.res_alloc    = 1'b1;
              cmd_o.alloc_commit = 1'b1;
              if (sts_i.count_zero) begin
                state_d = S_DONE;
              end else begin
                ret_d   = R_DONE;
                state_d = S_CLEAR;
              end
            end else begin
              cmd_o.res_status = ST_EXHAUSTED;
              state_d          = S_DONE;
            end
          end
          default: begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_OK;
            state_d          = S_DONE;
          end
        endcase
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.leaf_lvl) begin
          if (sts_i.entry_zero) begin
            if (is_query) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ST_OK;
              state_d          = S_DONE;
            end else if (sts_i.can_fresh) begin
              cmd_o.fresh_clear = 1'b1;
              ret_d             = R_LINK;
              state_d           = S_CLEAR;
            end else begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ST_EXHAUSTED;
              state_d          = S_DONE;
            end
          end else if (sts_i.ptr_ok) begin
            cmd_o.descend = 1'b1;
            state_d       = S_READ;
          end else begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = is_query ? ST_OK : ST_EXHAUSTED;
            state_d          = S_DONE;
          end
        end else begin
          cmd_o.res_set = 1'b1;
          state_d       = S_DONE;
          if (is_query) begin
            cmd_o.res_status = ST_OK;
            cmd_o.res_mapped = !sts_i.entry_zero;
          end else if (!sts_i.entry_zero) begin
            cmd_o.res_status = ST_MAPPED;
          end else begin
            cmd_o.res_status = ST_OK;
            cmd_o.leaf_write = 1'b1;
          end
        end
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = S_READ;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ret_q       <= R_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/fptb_datapath.sv
// Datapath with the table store, walk registers, page allocator and result registers.
`timescale 1ns / 1ps

module fptb_datapath
  import fptb_pkg::*;
#(
  parameter int unsigned POOL_PAGES = POOL_PAGES_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic [VA_W-1:0] cfg_data_i,
  input  req_t            req_i,
  input  dp_cmd_t         cmd_i,
  output dp_sts_t         sts_o,
  output rsp_t            rsp_o
);

  localparam int unsigned PageW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned AddrW = PageW + IDX_W;
  localparam int unsigned Depth = POOL_PAGES * ENTRIES_PER_PAGE;
  localparam int unsigned SumW  = ((PageW > CNT_W) ? PageW : CNT_W) + 1;
  localparam int unsigned FreeW = PageW + 1;
  localparam int unsigned GpnW  = VA_W - OFFSET_W;
  localparam int unsigned PtrW  = ENTRY_W - OFFSET_W;

  req_t                req_q;
  rsp_t                res_q;
  rsp_t                out_q;
  logic [VA_W-1:0]     base_q;
  logic [PageW-1:0]    next_free_q;
  logic [PageW-1:0]    page_q;
  logic [PageW-1:0]    clr_last_page_q;
  logic [1:0]          lvl_q;
  logic [AddrW-1:0]    clr_addr_q;
  logic [ENTRY_W-1:0]  mem [Depth];
  logic [ENTRY_W-1:0]  rdata_q;

  logic [IDX_W-1:0]    idx;
  logic [AddrW-1:0]    slot;
  logic [AddrW-1:0]    mem_addr;
  logic                mem_we;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [PtrW-1:0]     ptr_diff;
  logic [GpnW:0]       fresh_gpn;
  logic [GpnW-1:0]     alloc_gpn;
  logic [SumW-1:0]     alloc_sum;
  logic [FreeW-1:0]    fresh_sum;

  always_comb begin
    case (lvl_q)
      2'd0:    idx = req_q.virt_addr[47:39];
      2'd1:    idx = req_q.virt_addr[38:30];
      2'd2:    idx = req_q.virt_addr[29:21];
      default: idx = req_q.virt_addr[20:12];
    endcase
  end

  assign slot      = {page_q, idx};
  assign fresh_gpn = {1'b0, base_q[VA_W-1:OFFSET_W]} + (GpnW+1)'(next_free_q);
  assign alloc_gpn = base_q[VA_W-1:OFFSET_W] + GpnW'(next_free_q);
  assign alloc_sum = SumW'(next_free_q) + SumW'(req_q.num_pages);
  assign fresh_sum = FreeW'(next_free_q) + FreeW'(1);
  assign ptr_diff  = rdata_q[ENTRY_W-1:OFFSET_W]
                   - PtrW'(base_q[VA_W-1:OFFSET_W]);

  always_comb begin
    mem_addr  = slot;
    mem_we    = 1'b0;
    mem_wdata = '0;
    if (cmd_i.clr_step) begin
      mem_addr = clr_addr_q;
      mem_we   = 1'b1;
    end else if (cmd_i.link) begin
      mem_we    = 1'b1;
      mem_wdata = {(ENTRY_W - OFFSET_W - GpnW - 1)'(0), fresh_gpn, ENTRY_FLAGS};
    end else if (cmd_i.leaf_write) begin
      mem_we    = 1'b1;
      mem_wdata = {(ENTRY_W - PA_W)'(0), req_q.leaf_pa[PA_W-1:OFFSET_W], ENTRY_FLAGS};
    end
  end

  always_comb begin
    sts_o.op         = req_q.op;
    sts_o.misaligned = (|req_q.virt_addr[OFFSET_W-1:0]) || (|req_q.leaf_pa[OFFSET_W-1:0]);
    sts_o.can_alloc  = alloc_sum < SumW'(POOL_PAGES);
    sts_o.count_zero = (req_q.num_pages == '0);
    sts_o.can_fresh  = fresh_sum < FreeW'(POOL_PAGES);
    sts_o.entry_zero = (rdata_q == '0);
    sts_o.ptr_ok     = ptr_diff < PtrW'(POOL_PAGES);
    sts_o.leaf_lvl   = (lvl_q == 2'd3);
    sts_o.clr_last   = (clr_addr_q == {clr_last_page_q, {IDX_W{1'b1}}});
  end

  assign rsp_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q          <= '0;
      next_free_q     <= PageW'(1);
      page_q          <= '0;
      lvl_q           <= '0;
      clr_addr_q      <= '0;
      clr_last_page_q <= PageW'(POOL_PAGES - 1);
    end else begin
      if (cfg_valid_i) begin
        base_q <= cfg_data_i;
      end
      if (cmd_i.walk_start) begin
        page_q <= '0;
        lvl_q  <= '0;
      end
      if (cmd_i.descend) begin
        page_q <= ptr_diff[PageW-1:0];
        lvl_q  <= lvl_q + 2'd1;
      end
      if (cmd_i.fresh_clear) begin
        clr_addr_q      <= {next_free_q, IDX_W'(0)};
        clr_last_page_q <= next_free_q;
      end
      if (cmd_i.link) begin
        page_q      <= next_free_q;
        next_free_q <= fresh_sum[PageW-1:0];
        lvl_q       <= lvl_q + 2'd1;
      end
      if (cmd_i.alloc_commit) begin
        clr_addr_q      <= {next_free_q, IDX_W'(0)};
        clr_last_page_q <= alloc_sum[PageW-1:0] - PageW'(1);
        next_free_q     <= alloc_sum[PageW-1:0];
      end
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.res_set) begin
      res_q.status      <= cmd_i.res_status;
      res_q.is_mapped   <= cmd_i.res_mapped;
      res_q.alloc_addr  <= cmd_i.res_alloc ? {alloc_gpn, OFFSET_W'(0)} : '0;
      res_q.alloc_bytes <= cmd_i.res_alloc ? {req_q.num_pages, OFFSET_W'(0)} : '0;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[mem_addr];
    end
  end

endmodule

FILE: rtl/four_level_page_table_builder_unit.sv
// Top level of the four-level page table builder: controller, datapath and checks.
// A map or query walks the tables from request to result; each table page allocated on
// the way is cleared before it is linked, one entry a cycle.
// An allocate request clears the pages it takes; one request is in work at a time.
// After reset the block clears its whole table store before it accepts a request;
// configuration writes are taken at any time.
`timescale 1ns / 1ps

module four_level_page_table_builder_unit
  import fptb_pkg::*;
#(
  parameter int unsigned POOL_PAGES = POOL_PAGES_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [VA_W-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  req_t            in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rsp_t            out_rsp_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  fptb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fptb_datapath #(
    .POOL_PAGES (POOL_PAGES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (out_rsp_o)
  );

  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.mem_rd, cmd.clr_step, cmd.link, cmd.leaf_write}))
    else $error("Table store port used twice in one cycle.");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> !in_ready_o)
    else $error("Request accepted during a clearing sweep.");

  a_link_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.link |-> sts.can_fresh)
    else $error("Table page linked without room in the pool.");

  a_descend_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.descend |-> (sts.ptr_ok && !sts.entry_zero))
    else $error("Walk descended through an invalid entry.");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("Result loaded without raising valid.");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the four-level page table builder.
`timescale 1ns / 1ps

module tb;
  import fptb_pkg::*;

  localparam int unsigned POOL         = POOL_PAGES_DEFAULT;
  localparam int unsigned DEPTH        = POOL * ENTRIES_PER_PAGE;
  localparam int unsigned PREFIX_W     = VA_W - IDX_W - OFFSET_W;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 280;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned LIMIT_CYCLES = 1500000;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  typedef logic [ENTRY_W-1:0] entry_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [VA_W-1:0] cfg_data_i  = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  req_t            in_req_i    = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  rsp_t            out_rsp_o;

  four_level_page_table_builder_unit #(
    .POOL_PAGES(POOL)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  entry_t          pt_mem [DEPTH];
  int unsigned     next_free;
  logic [VA_W-1:0] table_base;

  req_t            req_feed[$];
  rsp_t            expected_rsp[$];
  logic [VA_W-1:0] mapped_va[$];
  logic [PREFIX_W-1:0] prefixes [8];

  bit          req_taken   = 1'b0;
  bit          hold_off    = 1'b0;
  int unsigned sender_idle = 0;
  int unsigned recv_stall  = 0;
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;
  int unsigned status_seen [4];
  int unsigned queries     = 0;
  int unsigned query_hits  = 0;

  function automatic entry_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic entry_t pool_origin();
    return entry_t'({table_base[VA_W-1:OFFSET_W], {OFFSET_W{1'b0}}});
  endfunction

  function automatic entry_t guest_addr(int unsigned pg);
    return pool_origin() + (entry_t'(pg) << OFFSET_W);
  endfunction

  function automatic logic [IDX_W-1:0] level_idx(logic [VA_W-1:0] va, int lvl);
    return va[VA_W-1-IDX_W*lvl -: IDX_W];
  endfunction

  function automatic bit entry_target(entry_t e, output int unsigned pg);
    entry_t off;
    off = {e[ENTRY_W-1:OFFSET_W], {OFFSET_W{1'b0}}} - pool_origin();
    if ((off >> OFFSET_W) >= entry_t'(POOL)) return 1'b0;
    pg = int'(off >> OFFSET_W);
    return 1'b1;
  endfunction

  function automatic bit take_pages(int unsigned cnt, output int unsigned first);
    int unsigned i;
    if (next_free + cnt >= POOL) return 1'b0;
    for (i = next_free * ENTRIES_PER_PAGE; i < (next_free + cnt) * ENTRIES_PER_PAGE; i++) begin
      pt_mem[i] = '0;
    end
    first = next_free;
    next_free += cnt;
    return 1'b1;
  endfunction

  function automatic logic [1:0] walk_map(logic [VA_W-1:0] va, logic [PA_W-1:0] pa);
    int unsigned pg;
    int unsigned slot;
    int unsigned fresh;
    int lvl;
    if (va[OFFSET_W-1:0] != '0 || pa[OFFSET_W-1:0] != '0) return ST_MISALIGNED;
    pg = 0;
    for (lvl = 0; lvl < 3; lvl++) begin
      slot = pg * ENTRIES_PER_PAGE + level_idx(va, lvl);
      if (pt_mem[slot] == '0) begin
        if (!take_pages(1, fresh)) return ST_EXHAUSTED;
        pt_mem[slot] = guest_addr(fresh) | entry_t'(ENTRY_FLAGS);
      end
      if (!entry_target(pt_mem[slot], pg)) return ST_EXHAUSTED;
    end
    slot = pg * ENTRIES_PER_PAGE + level_idx(va, 3);
    if (pt_mem[slot] != '0) return ST_MAPPED;
    pt_mem[slot] = entry_t'(pa) | entry_t'(ENTRY_FLAGS);
    return ST_OK;
  endfunction

  function automatic bit walk_query(logic [VA_W-1:0] va);
    int unsigned pg;
    entry_t e;
    int lvl;
    pg = 0;
    for (lvl = 0; lvl < 3; lvl++) begin
      e = pt_mem[pg * ENTRIES_PER_PAGE + level_idx(va, lvl)];
      if (e == '0) return 1'b0;
      if (!entry_target(e, pg)) return 1'b0;
    end
    return pt_mem[pg * ENTRIES_PER_PAGE + level_idx(va, 3)] != '0;
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t p;
    int unsigned first;
    entry_t addr;
    p = '0;
    case (r.op)
      OP_MAP: begin
        p.status = walk_map(r.virt_addr, r.leaf_pa);
      end
      OP_QUERY: begin
        p.is_mapped = walk_query(r.virt_addr);
      end
      OP_ALLOC: begin
        if (take_pages(r.num_pages, first)) begin
          addr = guest_addr(first);
          p.alloc_addr = addr[VA_W-1:0];
          p.alloc_bytes = {r.num_pages, {OFFSET_W{1'b0}}};
        end else begin
          p.status = ST_EXHAUSTED;
        end
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  function automatic req_t make_req(logic [1:0] op, logic [VA_W-1:0] va,
                                    logic [PA_W-1:0] pa, logic [CNT_W-1:0] cnt);
    req_t r;
    r.op = op;
    r.virt_addr = va;
    r.leaf_pa = pa;
    r.num_pages = cnt;
    return r;
  endfunction

  function automatic logic [VA_W-1:0] pick_va();
    if ($urandom_range(99) < 5) return VA_W'(rand64()) & ~VA_W'(12'hFFF);
    return {prefixes[$urandom_range(7)], IDX_W'($urandom), {OFFSET_W{1'b0}}};
  endfunction

  function automatic req_t random_req();
    req_t r;
    int unsigned roll;
    roll = $urandom_range(99);
    r.op = roll < 50 ? OP_MAP : roll < 85 ? OP_QUERY : roll < 95 ? OP_ALLOC : OP_UNUSED;
    r.virt_addr = VA_W'(rand64());
    r.leaf_pa = PA_W'(rand64());
    r.num_pages = CNT_W'($urandom);
    case (r.op)
      OP_MAP: begin
        if (mapped_va.size() != 0 && $urandom_range(9) == 0) begin
          r.virt_addr = mapped_va[$urandom_range(mapped_va.size() - 1)];
        end else begin
          r.virt_addr = pick_va();
        end
        if ($urandom_range(99) < 4) r.virt_addr[OFFSET_W-1:0] = OFFSET_W'($urandom);
        if ($urandom_range(99) >= 8) r.leaf_pa[OFFSET_W-1:0] = '0;
      end
      OP_QUERY: begin
        if (mapped_va.size() != 0 && $urandom_range(99) < 60) begin
          r.virt_addr = mapped_va[$urandom_range(mapped_va.size() - 1)];
        end else begin
          r.virt_addr = pick_va();
        end
        r.virt_addr[OFFSET_W-1:0] = OFFSET_W'($urandom);
      end
      OP_ALLOC: begin
        roll = $urandom_range(99);
        r.num_pages = roll < 25 ? CNT_W'(64 + $urandom_range(63)) : roll < 45 ? 7'd1 : 7'd0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic bit field_ok(string name, entry_t want, entry_t got);
    if (want === got) return 1'b1;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk_i) begin : monitor
    rsp_t want;
    bit bad;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) table_base = cfg_data_i;
      req_taken = in_valid_i && in_ready_o;
      if (req_taken) begin
        want = predict_rsp(in_req_i);
        expected_rsp.push_back(want);
        if (in_req_i.op == OP_MAP && want.status == ST_OK) begin
          mapped_va.push_back(in_req_i.virt_addr);
        end
        if (in_req_i.op == OP_QUERY) begin
          queries++;
          if (want.is_mapped) query_hits++;
        end
        status_seen[want.status]++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_rsp.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got 0x%0h", $time, out_rsp_o);
        end else begin
          want = expected_rsp.pop_front();
          bad = 1'b0;
          bad |= !field_ok("status", entry_t'(want.status), entry_t'(out_rsp_o.status));
          bad |= !field_ok("is_mapped", entry_t'(want.is_mapped), entry_t'(out_rsp_o.is_mapped));
          bad |= !field_ok("alloc_addr", entry_t'(want.alloc_addr),
                           entry_t'(out_rsp_o.alloc_addr));
          bad |= !field_ok("alloc_bytes", entry_t'(want.alloc_bytes),
                           entry_t'(out_rsp_o.alloc_bytes));
          if (bad) errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || req_taken) begin
      if (rst_ni && req_feed.size() != 0 && $urandom_range(99) >= sender_idle) begin
        in_req_i <= req_feed.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(posedge clk_i);
    while (req_feed.size() != 0 || in_valid_i || expected_rsp.size() != 0);
  endtask

  task automatic set_base(logic [VA_W-1:0] value);
    @(negedge clk_i);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [VA_W-1:0] phase_base [PHASES];
    int unsigned phase_send [PHASES];
    int unsigned phase_recv [PHASES];
    logic [VA_W-1:0] base;
    int unsigned ph;
    int unsigned n;
    int unsigned i;
    phase_base = '{48'h123, 48'hFFFF_FFFF_FFFF, 48'h0, 48'h1000, 48'h0, 48'h0};
    phase_send = '{86, 0, 23, 0, 23, 0};
    phase_recv = '{0, 86, 23, 0, 23, 0};
    for (i = 0; i < DEPTH; i++) pt_mem[i] = '0;
    next_free = 1;
    table_base = '0;
    for (i = 0; i < 4; i++) status_seen[i] = 0;
    prefixes[0] = '0;
    prefixes[1] = '1;
    for (i = 2; i < 8; i++) prefixes[i] = PREFIX_W'($urandom);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_base('0);
    req_feed.push_back(make_req(OP_QUERY, 48'h0, 52'h0, 7'd0));
    req_feed.push_back(make_req(OP_MAP, 48'h0, 52'h1000, 7'd0));
    req_feed.push_back(make_req(OP_MAP, 48'h0, 52'h2000, 7'd0));
    req_feed.push_back(make_req(OP_QUERY, 48'hFFF, 52'h0, 7'd0));
    req_feed.push_back(make_req(OP_MAP, 48'hFFFF_FFFF_F000, 52'hF_FFFF_FFFF_F000, 7'd0));
    req_feed.push_back(make_req(OP_QUERY, 48'hFFFF_FFFF_FFFF, 52'h0, 7'd0));
    req_feed.push_back(make_req(OP_MAP, 48'h1001, 52'h3000, 7'd0));
    req_feed.push_back(make_req(OP_MAP, 48'h2000, 52'h3FFF, 7'd0));
    req_feed.push_back(make_req(OP_QUERY, 48'h1000, 52'h0, 7'd0));
    req_feed.push_back(make_req(OP_MAP, 48'h1000, 52'h0, 7'd0));
    req_feed.push_back(make_req(OP_QUERY, 48'h1000, 52'h0, 7'd0));
    req_feed.push_back(make_req(OP_UNUSED, '1, '1, '1));
    req_feed.push_back(make_req(OP_ALLOC, 48'h0, 52'h0, 7'd0));
    req_feed.push_back(make_req(OP_ALLOC, 48'h0, 52'h0, 7'd1));
    req_feed.push_back(make_req(OP_ALLOC, 48'h0, 52'h0, 7'd3));
    req_feed.push_back(make_req(OP_ALLOC, 48'h0, 52'h0, 7'd64));
    req_feed.push_back(make_req(OP_ALLOC, 48'h0, 52'h0, 7'h7F));
    req_feed.push_back(make_req(OP_QUERY, 48'h20_0000, 52'h0, 7'd0));
    req_feed.push_back(make_req(OP_MAP, 48'h20_0000, 52'hABCD_E000, 7'd0));
    req_feed.push_back(make_req(OP_QUERY, 48'h20_0000, 52'h0, 7'd0));

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      base = phase_base[ph];
      if (ph == 4) base = VA_W'(rand64()) & ~VA_W'(12'hFFF);
      set_base(base);
      sender_idle = phase_send[ph];
      recv_stall = phase_recv[ph];
      if (ph == PHASES - 1 && next_free + 2 <= POOL) begin
        n = POOL - 2 - next_free;
        req_feed.push_back(make_req(OP_ALLOC, 48'h0, 52'h0, CNT_W'(n)));
        req_feed.push_back(make_req(OP_ALLOC, 48'h0, 52'h0, 7'd1));
      end
      for (i = 0; i < PHASE_ITEMS; i++) req_feed.push_back(random_req());
      if (ph == 3) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk_i);
            hold_off <= 1'b0;
          end
        join_none
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Ran %0d table_base settings: %0d ok, %0d misaligned,",
             PHASES + 1, status_seen[ST_OK], status_seen[ST_MISALIGNED]);
    $display("%0d already mapped, %0d exhausted; queries hit %0d of %0d; %0d pages taken.",
             status_seen[ST_MAPPED], status_seen[ST_EXHAUSTED],
             query_hits, queries, next_free);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/fptb_pkg.sv
rtl/fptb_ctrl.sv
rtl/fptb_datapath.sv
rtl/four_level_page_table_builder_unit.sv
verif/tb.sv
